@@ hdl/maf_pkg.sv @@
// ----------------------------------------------------------------------------
// maf_pkg: shared constants for the moving average filter
// Field widths, request codes and divider step count.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 6;
  localparam int SUM_W     = 22;
  localparam int AVG_W     = 16;
  localparam int DIV_STEPS = SUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [AVG_W-1:0]    avg_t;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

endpackage

`default_nettype wire

@@ hdl/moving_average_filter.sv @@
// ----------------------------------------------------------------------------
// moving_average_filter: boxcar moving average over the last N samples
//
// Input channel (in_valid / in_stall): one word is a request type and a
// 16-bit sample. An update writes the sample over the oldest slot of the
// ring; a clear zeroes every slot and keeps the ring position. Each word
// returns one word on the output channel (out_valid / out_stall): the floor
// of the window sum divided by the window length.
// An in-range update does the store read-modify-write (ST_RMW), then both kinds
// run the shared restoring divider (ST_DIV, one quotient bit a cycle, the last
// step waiting while the output stalls); the result is registered and a new
// word can be taken right after. in_stall stays high while busy.
// The result sits in an output register; while the receiver stalls, the next
// word is still taken and only its last divider step waits for the register.
// Config (cfg_valid / cfg_ready): writes the window length. Values of zero or
// not below MAX_WINDOW are dropped; a legal write clears the ring and position.
// Reset (rst_n low, synchronous): window length 8 (MAX_WINDOW - 1 if smaller),
// all slots read as zero through per-slot valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_req_type,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [AVG_W-1:0]    out_average,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [LEN_W-1:0]    cfg_window_length
);

  // only slots below the 6-bit window length are ever touched
  localparam int   STORE_DEPTH = (MAX_WINDOW < 64) ? MAX_WINDOW : 64;
  localparam int   AW          = $clog2(STORE_DEPTH);
  localparam len_t RESET_LEN   = (MAX_WINDOW <= 8) ? LEN_W'(MAX_WINDOW - 1) : LEN_W'(8);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  len_t                   len_r, len_nxt;
  len_t                   pos_r, pos_nxt;
  sum_t                   sum_r, sum_nxt;
  logic [STORE_DEPTH-1:0] vld_r, vld_nxt;
  sample_t                smp_r, smp_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  len_t                   rem_r, rem_nxt;
  logic [DCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  avg_t                   avg_r, avg_nxt;

  logic          in_acc, cfg_acc, cfg_legal;
  logic [AW-1:0] idx;
  sample_t       ram_rdata, old_smp;
  logic          ram_we;
  sum_t          sum_upd;
  logic [LEN_W:0] pos_inc, trial;
  logic          qbit;
  len_t          rem_step;
  logic          out_busy;

  assign in_stall  = !rst_n || (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_legal = (cfg_window_length != '0) &&
                     (32'(cfg_window_length) < 32'(MAX_WINDOW));

  assign idx     = pos_r[AW-1:0];
  assign ram_we  = (state_r == ST_RMW);
  assign old_smp = vld_r[idx] ? ram_rdata : '0;
  assign sum_upd = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
  assign pos_inc = {1'b0, pos_r} + (LEN_W+1)'(1);

  maf_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(smp_r),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // restoring divider step: one quotient bit per cycle, the last step held while the output stalls
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign qbit     = (trial >= {1'b0, len_r});
  assign rem_step = qbit ? LEN_W'(trial - {1'b0, len_r}) : trial[LEN_W-1:0];
  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    vld_nxt       = vld_r;
    smp_nxt       = smp_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc && cfg_legal) begin
          len_nxt = cfg_window_length;
          vld_nxt = '0;
          sum_nxt = '0;
          pos_nxt = '0;
        end else if (in_acc) begin
          rem_nxt = '0;
          cnt_nxt = '0;
          if (in_req_type == REQ_CLEAR) begin
            vld_nxt   = '0;
            sum_nxt   = '0;
            quo_nxt   = '0;
            state_nxt = ST_DIV;
          end else if (pos_r < len_r) begin
            smp_nxt   = in_sample;
            state_nxt = ST_RMW;
          end else begin
            // stale position: wrap without touching the store
            pos_nxt   = '0;
            quo_nxt   = sum_r;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_RMW: begin
        vld_nxt[idx] = 1'b1;
        sum_nxt      = sum_upd;
        quo_nxt      = sum_upd;
        pos_nxt      = (pos_inc >= {1'b0, len_r}) ? '0 : pos_inc[LEN_W-1:0];
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (!(cnt_r == DIV_LAST && out_busy)) begin
          quo_nxt = {quo_r[SUM_W-2:0], qbit};
          rem_nxt = rem_step;
          cnt_nxt = cnt_r + DCNT_W'(1);
          if (cnt_r == DIV_LAST) begin
            avg_nxt       = AVG_W'({quo_r[SUM_W-2:0], qbit});
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= RESET_LEN;
      pos_r       <= '0;
      sum_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    avg_r <= avg_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_average = avg_r;

endmodule

`default_nettype wire

@@ hdl/maf_ram.sv @@
// ----------------------------------------------------------------------------
// maf_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/maf_checker.sv @@
// ----------------------------------------------------------------------------
// maf_checker: port-level checks for the moving average filter
// Watches the top-level handshakes; bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_checker
  import maf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [AVG_W-1:0] out_average,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready
);

  // a taken word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a word");

  // results only come out of the divider, which runs while stalled
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while block was idle");

  // config write and input word never taken together
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("config write accepted alongside an input word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled result changed");

endmodule

bind moving_average_filter maf_checker u_maf_checker (.*);

`default_nettype wire
